// ===== rtl/core/four_voice_wavetable_synth_core_defines.svh =====
// Assertion macros shared by the core's RTL files.
// FVWS_ASSERT checks a property on every clock edge outside reset.
// FVWS_ASSERT_NORST checks a property on every clock edge, reset included.
`ifndef FOUR_VOICE_WAVETABLE_SYNTH_CORE_DEFINES_SVH
`define FOUR_VOICE_WAVETABLE_SYNTH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FVWS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FVWS_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FVWS_ASSERT(name, prop, msg)
`define FVWS_ASSERT_NORST(name, prop, msg)
`endif

`endif

// ===== rtl/core/fvws_pkg.sv =====
package fvws_pkg;

  localparam int TABLE_COUNT_DEF = 8;
  localparam int TABLE_ENTRIES   = 1024;
  localparam int ENTRY_W         = $clog2(TABLE_ENTRIES);
  localparam int VOICES          = 4;
  localparam int VOICE_W         = $clog2(VOICES);
  localparam int PHASE_W         = 16;
  localparam int STEP_W          = 16;
  localparam int WORD_W          = 16;
  localparam int ADDR_W          = 13;
  localparam int VOL_W           = 8;
  localparam int SEL_W           = 3;
  localparam int DAC_W           = 12;
  localparam int SUM_W           = WORD_W + VOICE_W;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DAC_W-1:0] DAC_OFFSET = 12'd2047;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                      kind;
    logic [ADDR_W-1:0]              addr;
    logic [WORD_W-1:0]              data;
    logic [VOL_W-1:0]               volume;
    logic [VOICES-1:0][STEP_W-1:0]  steps;
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/core/fvws_in_if.sv =====
interface fvws_in_if;
  import fvws_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] table_addr;
  logic signed [WORD_W-1:0] table_data;
  logic [VOL_W-1:0]  volume;
  logic [STEP_W-1:0] step_one;
  logic [STEP_W-1:0] step_two;
  logic [STEP_W-1:0] step_three;
  logic [STEP_W-1:0] step_four;

  modport source (
    output valid, req_type, table_addr, table_data, volume,
           step_one, step_two, step_three, step_four,
    input  ready
  );

  modport sink (
    input  valid, req_type, table_addr, table_data, volume,
           step_one, step_two, step_three, step_four,
    output ready
  );

endinterface

// ===== rtl/core/fvws_out_if.sv =====
interface fvws_out_if;
  import fvws_pkg::*;

  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_code;

  modport source (
    output valid, dac_code,
    input  ready
  );

  modport sink (
    input  valid, dac_code,
    output ready
  );

endinterface

// ===== rtl/core/four_voice_wavetable_synth_core.sv =====
// Four-voice wavetable oscillator with a 12-bit DAC word output.
// The in_chan channel carries two kinds of transactions: a table write stores one
// signed word at table number times 1024 plus entry, and a sample tick carries the
// volume and the four phase steps. Writes beyond the memory are accepted and dropped.
// Each tick returns one out_chan transaction holding the sample of the previous tick
// plus 2047, low 12 bits; writes return nothing.
// Accepted transactions wait in a four-entry queue. A tick occupies the single
// wavetable read port with one read per voice, so a new tick starts only after
// the previous tick's voice reads are done. A tick's result passes through the
// read, sum, magnitude and output registers.
// cfg_wr_en with cfg_wr_data selects the table the voices read.
// Reset clears the phases, the held sample, the table select and the queue; the
// wavetable memory keeps its contents and is undefined until written.
// When out_chan is stalled the result stays registered and the back end freezes,
// while in_chan keeps accepting until the queue is full.
module four_voice_wavetable_synth_core #(
  parameter int TABLE_COUNT = fvws_pkg::TABLE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fvws_pkg::SEL_W-1:0] cfg_wr_data,
  fvws_in_if.sink                    in_chan,
  fvws_out_if.source                 out_chan
);
  import fvws_pkg::*;

  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t status;

  fvws_front #(
    .TABLE_COUNT(TABLE_COUNT)
  ) u_front (
    .in_chan    (in_chan),
    .queue_full (status.full),
    .push       (push),
    .cmd        (push_cmd)
  );

  fvws_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  fvws_back #(
    .TABLE_COUNT(TABLE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

// ===== rtl/core/fvws_front.sv =====
module fvws_front #(
  parameter int TABLE_COUNT = fvws_pkg::TABLE_COUNT_DEF
) (
  fvws_in_if.sink        in_chan,
  input  logic           queue_full,
  output logic           push,
  output fvws_pkg::cmd_t cmd
);
  import fvws_pkg::*;

  localparam int MEM_WORDS = TABLE_COUNT * TABLE_ENTRIES;

  logic accept;
  logic in_range;
  logic is_write;

  assign in_chan.ready = !queue_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_write      = (in_chan.req_type == REQ_WRITE);
  assign in_range      = (32'(in_chan.table_addr) < MEM_WORDS);

  // Writes beyond the memory are taken and dropped here.
  assign push = accept && (!is_write || in_range);

  always_comb begin
    cmd.kind     = is_write ? CMD_WRITE : CMD_TICK;
    cmd.addr     = in_chan.table_addr;
    cmd.data     = in_chan.table_data;
    cmd.volume   = in_chan.volume;
    cmd.steps[0] = in_chan.step_one;
    cmd.steps[1] = in_chan.step_two;
    cmd.steps[2] = in_chan.step_three;
    cmd.steps[3] = in_chan.step_four;
  end

endmodule

// ===== rtl/core/fvws_cmd_fifo.sv =====
`include "four_voice_wavetable_synth_core_defines.svh"

module fvws_cmd_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  fvws_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output fvws_pkg::cmd_t          head,
  output fvws_pkg::queue_status_t status
);
  import fvws_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign head              = entry_r[rd_ptr_r];
  assign status.head_valid = (count_r != '0);
  assign status.full       = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `FVWS_ASSERT(a_count_bounded, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `FVWS_ASSERT(a_no_pop_empty, pop |-> count_r != '0, "pop from an empty queue")
  `FVWS_ASSERT(a_no_push_full, push |-> count_r != QCNT_W'(QUEUE_DEPTH), "push into a full queue")

endmodule

// ===== rtl/core/fvws_back.sv =====
`include "four_voice_wavetable_synth_core_defines.svh"

module fvws_back #(
  parameter int TABLE_COUNT = fvws_pkg::TABLE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fvws_pkg::SEL_W-1:0]    cfg_wr_data,
  input  fvws_pkg::cmd_t                head,
  input  fvws_pkg::queue_status_t       status,
  output logic                          pop,
  fvws_out_if.source                    out_chan
);
  import fvws_pkg::*;

  localparam int MEM_WORDS = TABLE_COUNT * TABLE_ENTRIES;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int PROD_W    = WORD_W + VOL_W;

  logic [WORD_W-1:0] mem [MEM_WORDS];

  logic [SEL_W-1:0]   wave_sel_r;
  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [VOICES-1:0][STEP_W-1:0] step_r;
  logic [VOL_W-1:0]   vol_r;
  logic               busy_r;
  logic [VOICE_W-1:0] voice_r;

  logic               rd_valid_r;
  logic               rd_first_r;
  logic               rd_last_r;
  logic               rd_zero_r;
  logic [VOL_W-1:0]   rd_vol_r;
  logic [WORD_W-1:0]  rd_data_r;

  logic signed [SUM_W-1:0] acc_r;
  logic               sum_valid_r;
  logic [VOL_W-1:0]   sum_vol_r;

  logic               mag_valid_r;
  logic [WORD_W-1:0]  mag_r;
  logic               neg_r;
  logic [VOL_W-1:0]   mag_vol_r;

  logic [WORD_W-1:0]  held_r;
  logic               out_valid_r;
  logic [DAC_W-1:0]   out_dac_r;

  logic               en;
  logic               pop_tick;
  logic               mem_we;
  logic               re;
  logic [VOICE_W-1:0] rd_voice;
  logic [PHASE_W-1:0] rd_phase;
  logic [STEP_W-1:0]  rd_step;
  logic [MEM_AW-1:0]  rd_addr;
  logic               sel_ok;
  logic [WORD_W-1:0]  rd_word;
  logic signed [SUM_W-1:0] acc_nxt;
  logic signed [SUM_W-1:0] sum_adj;
  logic [WORD_W-1:0]  avg;
  logic               avg_pos;
  logic [PROD_W-1:0]  prod;
  logic [WORD_W-1:0]  scaled;
  logic [WORD_W-1:0]  held_nxt;

  assign en       = !out_valid_r || out_chan.ready;
  assign pop      = en && !busy_r && status.head_valid;
  assign pop_tick = pop && (head.kind == CMD_TICK);
  assign mem_we   = pop && (head.kind == CMD_WRITE);
  assign re       = en && (pop_tick || busy_r);

  assign rd_voice = busy_r ? voice_r : '0;
  assign rd_phase = phase_r[rd_voice];
  assign rd_step  = busy_r ? step_r[voice_r] : head.steps[0];
  assign sel_ok   = (32'(wave_sel_r) < TABLE_COUNT);
  assign rd_addr  = MEM_AW'({wave_sel_r, rd_phase[PHASE_W-1 -: ENTRY_W]});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[MEM_AW'(head.addr)] <= head.data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r <= '0;
    end else if (cfg_wr_en) begin
      wave_sel_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      voice_r <= '0;
      for (int v = 0; v < VOICES; v++) begin
        phase_r[v] <= '0;
      end
    end else begin
      if (re) begin
        phase_r[rd_voice] <= rd_phase + rd_step;
      end
      if (pop_tick) begin
        busy_r  <= 1'b1;
        voice_r <= VOICE_W'(1);
      end else if (busy_r && en) begin
        voice_r <= voice_r + 1'b1;
        if (voice_r == VOICE_W'(VOICES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_tick) begin
      step_r <= head.steps;
      vol_r  <= head.volume;
    end
    if (re) begin
      rd_first_r <= !busy_r;
      rd_last_r  <= busy_r && (voice_r == VOICE_W'(VOICES - 1));
      rd_zero_r  <= !sel_ok;
      rd_vol_r   <= busy_r ? vol_r : head.volume;
    end
  end

  assign rd_word = rd_zero_r ? '0 : rd_data_r;
  assign acc_nxt = (rd_first_r ? SUM_W'(0) : acc_r)
                 + {{VOICE_W{rd_word[WORD_W-1]}}, rd_word};

  always_ff @(posedge clk) begin
    if (en && rd_valid_r) begin
      acc_r <= acc_nxt;
      if (rd_last_r) begin
        sum_vol_r <= rd_vol_r;
      end
    end
  end

  assign sum_adj = acc_r + (acc_r[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
  assign avg     = sum_adj[SUM_W-1:VOICE_W];
  assign avg_pos = !avg[WORD_W-1] && (avg != '0);

  always_ff @(posedge clk) begin
    if (en && sum_valid_r) begin
      mag_r     <= avg_pos ? avg : WORD_W'(0) - avg;
      neg_r     <= !avg_pos;
      mag_vol_r <= sum_vol_r;
    end
  end

  assign prod     = mag_r * mag_vol_r;
  assign scaled   = prod[PROD_W-1:VOL_W];
  assign held_nxt = neg_r ? WORD_W'(0) - scaled : scaled;

  always_ff @(posedge clk) begin
    if (en && mag_valid_r) begin
      out_dac_r <= held_r[DAC_W-1:0] + DAC_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
      mag_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else if (en) begin
      rd_valid_r  <= re;
      sum_valid_r <= rd_valid_r && rd_last_r;
      mag_valid_r <= sum_valid_r;
      out_valid_r <= mag_valid_r;
      if (mag_valid_r) begin
        held_r <= held_nxt;
      end
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.dac_code = out_dac_r;

  `FVWS_ASSERT(a_no_write_while_reading, busy_r |-> !mem_we, "table write during voice reads")
  `FVWS_ASSERT(a_last_read_closes_sum, (en && rd_valid_r && rd_last_r) |=> sum_valid_r,
               "last voice read did not complete the sum")
  `FVWS_ASSERT(a_held_frozen_in_stall, !en |=> $stable(held_r), "held sample moved in a stall")
  `FVWS_ASSERT_NORST(a_reset_clears_output, !rst_n |=> !out_valid_r,
                     "output valid after reset")

endmodule
